FILE: rtl/sparse_set_component_store_macros.svh
// Assertion macros shared by the sparse set component store RTL.
`ifndef SPARSE_SET_COMPONENT_STORE_MACROS_SVH
`define SPARSE_SET_COMPONENT_STORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSCS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSCS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SSCS_ASSERT(name, clk, rst_n, prop, msg)
`define SSCS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: rtl/sscs_pkg.sv
// Constants, codes and entry types of the sparse set component store.
`timescale 1ns / 1ps
package sscs_pkg;

	localparam int ENTITY_COUNT = 1024;
	localparam int DATA_WIDTH   = 32;

	localparam int SLOT_W = $clog2(ENTITY_COUNT);
	localparam int CNT_W  = $clog2(ENTITY_COUNT + 1);

	// fixed request/response field widths
	localparam int OP_W      = 3;
	localparam int ENT_W     = 10;
	localparam int SIDX_W    = 10;
	localparam int WDATA_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int PSLOT_W   = 10;
	localparam int RDATA_W   = 32;
	localparam int LCOUNT_W  = 11;

	localparam int IN_FIELDS_W  = OP_W + ENT_W + SIDX_W + WDATA_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATUS_W + PSLOT_W + ENT_W + RDATA_W + LCOUNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
	localparam logic [OP_W-1:0] OP_READ_ENT  = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE_ENT = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_SLOT = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_ALREADY     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_PRESENT = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_SLOT_RANGE  = 2'd3;

	// entity -> slot map entry
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
	} map_entry_t;

	// slot -> entity and component data
	typedef struct packed {
		logic [ENT_W-1:0]      ent;
		logic [DATA_WIDTH-1:0] data;
	} slot_entry_t;

endpackage

FILE: rtl/sparse_set_component_store.sv
// Sparse set component store: entity map, packed slot table and request sequencer.
`timescale 1ns / 1ps
// Sequencer path per request: add, write by entity, read by slot and every miss go through
// ST_LOOK; read by entity and add of a present entity add ST_DATA; remove adds ST_DATA and ST_FIX.
// A new request is taken only in ST_IDLE, after the last one is through, because of the dependent
// accesses to the one-port entity map and slot table; a waiting response does not block the next accept.
// Reset: arst_n clears control state, then a pass clears the valid bits of all 1024 entity map
// entries, one entry per cycle; s_axis_tready stays low during that pass.
`include "sparse_set_component_store_macros.svh"
module sparse_set_component_store
	import sscs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [2:0] opcode, [12:3] target_ent, [22:13] slot_index, [54:23] write_data, rest zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [1:0] status, [11:2] packed_slot, [21:12] entity_out, [53:22] data_out,
	// [64:54] live_count, rest zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// sequencer states
	localparam logic [2:0] ST_CLR  = 3'd0;  // clearing the entity map after reset
	localparam logic [2:0] ST_IDLE = 3'd1;  // waiting for a request
	localparam logic [2:0] ST_LOOK = 3'd2;  // entity map entry and first slot read are back
	localparam logic [2:0] ST_DATA = 3'd3;  // slot entry of the named entity is back
	localparam logic [2:0] ST_FIX  = 3'd4;  // remove: drop the removed entity from the map

	// unpack the request
	logic [OP_W-1:0]    in_op;
	logic [ENT_W-1:0]   in_ent;
	logic [SIDX_W-1:0]  in_si;
	logic [WDATA_W-1:0] in_wd;
	logic               accept;

	assign in_op  = s_axis_tdata[OP_W-1:0];
	assign in_ent = s_axis_tdata[OP_W+ENT_W-1:OP_W];
	assign in_si  = s_axis_tdata[OP_W+ENT_W+SIDX_W-1:OP_W+ENT_W];
	assign in_wd  = s_axis_tdata[IN_FIELDS_W-1:OP_W+ENT_W+SIDX_W];

	// control state
	logic [2:0]        state_q, state_d;
	logic [SLOT_W-1:0] clr_q;
	logic [CNT_W-1:0]  count_q, count_d;

	// latched request
	logic [OP_W-1:0]       op_q;
	logic [ENT_W-1:0]      ent_q;
	logic [SIDX_W-1:0]     si_q;
	logic [DATA_WIDTH-1:0] wd_q;
	logic                  in_range_q;

	// remove bookkeeping
	slot_entry_t           last_q;
	logic [DATA_WIDTH-1:0] old_q;
	logic                  last_ld, old_ld;

	// memories: entity map (cleared after reset) and packed slot table
	map_entry_t  map_mem [ENTITY_COUNT];
	slot_entry_t slot_mem [ENTITY_COUNT];
	map_entry_t  map_rd_q;
	slot_entry_t slot_rd_q;

	logic              map_we, map_re;
	logic [SLOT_W-1:0] map_wa, map_ra;
	map_entry_t        map_wd;
	logic              slot_we, slot_re;
	logic [SLOT_W-1:0] slot_wa, slot_ra;
	slot_entry_t       slot_wd;

	// output register
	logic                  m_valid_q;
	logic [STATUS_W-1:0]   o_status_q, o_status;
	logic [PSLOT_W-1:0]    o_slot_q, o_slot;
	logic [ENT_W-1:0]      o_ent_q, o_ent;
	logic [RDATA_W-1:0]    o_data_q, o_data;
	logic [LCOUNT_W-1:0]   o_count_q;
	logic                  out_ld, out_free;
	logic                  present;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign present       = in_range_q && map_rd_q.valid;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		map_we   = 1'b0;
		map_wa   = SLOT_W'(ent_q);
		map_wd   = '0;
		map_re   = 1'b0;
		map_ra   = SLOT_W'(in_ent);
		slot_we  = 1'b0;
		slot_wa  = map_rd_q.slot;
		slot_wd  = '0;
		slot_re  = 1'b0;
		slot_ra  = map_rd_q.slot;
		last_ld  = 1'b0;
		old_ld   = 1'b0;
		out_ld   = 1'b0;
		o_status = STAT_NOT_PRESENT;
		o_slot   = '0;
		o_ent    = ent_q;
		o_data   = '0;
		unique case (state_q)
			ST_CLR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				map_wd = '0;
				if (clr_q == SLOT_W'(ENTITY_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					map_re  = 1'b1;
					slot_re = 1'b1;
					// read by slot needs its slot; remove needs the last slot
					if (in_op == OP_READ_SLOT) begin
						slot_ra = SLOT_W'(in_si);
					end else begin
						slot_ra = SLOT_W'(count_q - CNT_W'(1));
					end
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (out_free) begin
					state_d = ST_IDLE;
					unique case (op_q)
						OP_ADD: begin
							if (present) begin
								slot_re = 1'b1;
								state_d = ST_DATA;
							end else if (!in_range_q) begin
								out_ld = 1'b1;
							end else if (count_q == CNT_W'(ENTITY_COUNT)) begin
								out_ld   = 1'b1;
								o_status = STAT_ALREADY;
							end else begin
								// append at the end of the packed array, data cleared
								map_we        = 1'b1;
								map_wd.valid  = 1'b1;
								map_wd.slot   = SLOT_W'(count_q);
								slot_we       = 1'b1;
								slot_wa       = SLOT_W'(count_q);
								slot_wd.ent   = ent_q;
								slot_wd.data  = '0;
								count_d       = count_q + CNT_W'(1);
								out_ld        = 1'b1;
								o_status      = STAT_OK;
								o_slot        = PSLOT_W'(count_q);
							end
						end
						OP_REMOVE: begin
							if (present) begin
								last_ld = 1'b1;
								slot_re = 1'b1;
								state_d = ST_DATA;
							end else begin
								out_ld = 1'b1;
							end
						end
						OP_READ_ENT: begin
							if (present) begin
								slot_re = 1'b1;
								state_d = ST_DATA;
							end else begin
								out_ld = 1'b1;
							end
						end
						OP_WRITE_ENT: begin
							out_ld = 1'b1;
							if (present) begin
								// the slot already holds this entity
								slot_we      = 1'b1;
								slot_wd.ent  = ent_q;
								slot_wd.data = wd_q;
								o_status     = STAT_OK;
								o_slot       = PSLOT_W'(map_rd_q.slot);
								o_data       = RDATA_W'(wd_q);
							end
						end
						OP_READ_SLOT: begin
							out_ld = 1'b1;
							o_slot = PSLOT_W'(si_q);
							if (32'(si_q) < 32'(count_q)) begin
								o_status = STAT_OK;
								o_ent    = slot_rd_q.ent;
								o_data   = RDATA_W'(slot_rd_q.data);
							end else begin
								o_status = STAT_SLOT_RANGE;
								o_ent    = '0;
							end
						end
						default: begin
							out_ld = 1'b1;
							o_ent  = '0;
						end
					endcase
				end
			end
			ST_DATA: begin
				if (out_free) begin
					state_d = ST_IDLE;
					o_slot  = PSLOT_W'(map_rd_q.slot);
					o_data  = RDATA_W'(slot_rd_q.data);
					if (op_q == OP_REMOVE) begin
						// move the last slot into the freed one and repoint its entity
						slot_we      = 1'b1;
						slot_wd      = last_q;
						map_we       = 1'b1;
						map_wa       = SLOT_W'(last_q.ent);
						map_wd.valid = 1'b1;
						map_wd.slot  = map_rd_q.slot;
						old_ld       = 1'b1;
						state_d      = ST_FIX;
					end else begin
						out_ld   = 1'b1;
						o_status = (op_q == OP_ADD) ? STAT_ALREADY : STAT_OK;
					end
				end
			end
			ST_FIX: begin
				if (out_free) begin
					// written after the move, so removing the last slot clears the entry
					map_we   = 1'b1;
					map_wd   = '0;
					count_d  = count_q - CNT_W'(1);
					out_ld   = 1'b1;
					o_status = STAT_OK;
					o_slot   = PSLOT_W'(map_rd_q.slot);
					o_data   = RDATA_W'(old_q);
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (out_ld) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// request, remove and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= in_op;
			ent_q      <= in_ent;
			si_q       <= in_si;
			wd_q       <= DATA_WIDTH'(in_wd);
			in_range_q <= (32'(in_ent) < ENTITY_COUNT);
		end
		if (last_ld) begin
			last_q <= slot_rd_q;
		end
		if (old_ld) begin
			old_q <= slot_rd_q.data;
		end
		if (out_ld) begin
			o_status_q <= o_status;
			o_slot_q   <= o_slot;
			o_ent_q    <= o_ent;
			o_data_q   <= o_data;
			o_count_q  <= LCOUNT_W'(count_d);
		end
	end

	// entity map memory
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (map_re) begin
			map_rd_q <= map_mem[map_ra];
		end
	end

	// packed slot table memory
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_ra];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({o_count_q, o_data_q, o_ent_q, o_slot_q, o_status_q});

	`SSCS_ASSERT(a_count_range, clk, arst_n, count_q <= CNT_W'(ENTITY_COUNT), "live count above capacity")
	`SSCS_ASSERT(a_clr_blocks, clk, arst_n, (state_q == ST_CLR) |-> !s_axis_tready, "request taken during map clear")
	`SSCS_ASSERT(a_no_overwrite, clk, arst_n, out_ld |-> out_free, "response overwritten before taken")
	`SSCS_ASSERT_NEXT(a_accept_look, clk, arst_n, accept, state_q == ST_LOOK, "accepted request not looked up")
	`SSCS_ASSERT_NEXT(a_remove_dec, clk, arst_n, (state_q == ST_FIX) && out_free, count_q == $past(count_q) - CNT_W'(1), "remove did not shrink count")

endmodule
